// ===== hdl/stm_pkg.sv =====
package stm_pkg;

    // sizes and defaults
    localparam int DEF_MAX_DISPLAYS = 8;
    localparam int DEF_TEXT_DEPTH   = 256;
    localparam int ROWS             = 8;
    localparam int GLYPH_COUNT      = 85;
    localparam int GLYPH_W          = 7;
    localparam int DCNT_W           = 4;
    localparam int COL_W            = 3;
    localparam int FW_W             = 4;
    localparam int ROW_BITS_W       = 64;
    localparam int POS_MASK         = 'h1FF;
    localparam int IN_TDATA_W       = 8;
    localparam int OUT_TDATA_W      = 72;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 4;

    // item operations
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_APPEND  = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_COUNT  = 1'd0,
        REG_REVERSE_SCROLL = 1'd1
    } t_reg_idx;

    // eight row bytes held by one display cell
    typedef logic [ROWS-1:0][7:0] t_rows;

    // control for each cell of the chain; shift and reverse are shared, active is per cell
    typedef struct packed {
        logic shift;
        logic reverse;
        logic active;
    } t_cell_ctl;

    // font rows 0..7 of each glyph
    localparam logic [7:0] FONT_ROWS [GLYPH_COUNT][ROWS] = '{
        '{8'h30,8'h78,8'hCC,8'hCC,8'hFC,8'hCC,8'hCC,8'h00},
        '{8'hFC,8'h66,8'h66,8'h7C,8'h66,8'h66,8'hFC,8'h00},
        '{8'h3C,8'h66,8'hC0,8'hC0,8'hC0,8'h66,8'h3C,8'h00},
        '{8'hF8,8'h6C,8'h66,8'h66,8'h66,8'h6C,8'hF8,8'h00},
        '{8'hFE,8'h62,8'h68,8'h78,8'h68,8'h62,8'hFE,8'h00},
        '{8'hFE,8'h62,8'h68,8'h78,8'h68,8'h60,8'hF0,8'h00},
        '{8'h3C,8'h66,8'hC0,8'hC0,8'hCE,8'h66,8'h3E,8'h00},
        '{8'hCC,8'hCC,8'hCC,8'hFC,8'hCC,8'hCC,8'hCC,8'h00},
        '{8'h78,8'h30,8'h30,8'h30,8'h30,8'h30,8'h78,8'h00},
        '{8'h1E,8'h0C,8'h0C,8'h0C,8'hCC,8'hCC,8'h78,8'h00},
        '{8'hF6,8'h66,8'h6C,8'h78,8'h6C,8'h66,8'hF6,8'h00},
        '{8'hF0,8'h60,8'h60,8'h60,8'h62,8'h66,8'hFE,8'h00},
        '{8'hC6,8'hEE,8'hFE,8'hFE,8'hD6,8'hC6,8'hC6,8'h00},
        '{8'hC6,8'hE6,8'hF6,8'hDE,8'hCE,8'hC6,8'hC6,8'h00},
        '{8'h38,8'h6C,8'hC6,8'hC6,8'hC6,8'h6C,8'h38,8'h00},
        '{8'hFC,8'h66,8'h66,8'h7C,8'h60,8'h60,8'hF0,8'h00},
        '{8'h78,8'hCC,8'hCC,8'hCC,8'hDC,8'h78,8'h1C,8'h00},
        '{8'hFC,8'h66,8'h66,8'h7C,8'h6C,8'h66,8'hF6,8'h00},
        '{8'h78,8'hCC,8'hE0,8'h70,8'h1C,8'hCC,8'h78,8'h00},
        '{8'hFC,8'hB4,8'h30,8'h30,8'h30,8'h30,8'h78,8'h00},
        '{8'hCC,8'hCC,8'hCC,8'hCC,8'hCC,8'hCC,8'hFC,8'h00},
        '{8'hCC,8'hCC,8'hCC,8'hCC,8'hCC,8'h78,8'h30,8'h00},
        '{8'hC6,8'hC6,8'hC6,8'hD6,8'hFE,8'hEE,8'hC6,8'h00},
        '{8'hC6,8'hC6,8'h6C,8'h38,8'h38,8'h6C,8'hC6,8'h00},
        '{8'hCC,8'hCC,8'hCC,8'h78,8'h30,8'h30,8'h78,8'h00},
        '{8'hFE,8'hC6,8'h8C,8'h18,8'h32,8'h66,8'hFE,8'h00},
        '{8'h00,8'h00,8'h78,8'h0C,8'h7C,8'hCC,8'h76,8'h00},
        '{8'hE0,8'h60,8'h60,8'h7C,8'h66,8'h66,8'hDC,8'h00},
        '{8'h00,8'h00,8'h78,8'hCC,8'hC0,8'hCC,8'h78,8'h00},
        '{8'h1C,8'h0C,8'h0C,8'h7C,8'hCC,8'hCC,8'h76,8'h00},
        '{8'h00,8'h00,8'h78,8'hCC,8'hFC,8'hC0,8'h78,8'h00},
        '{8'h38,8'h6C,8'h60,8'hF0,8'h60,8'h60,8'hF0,8'h00},
        '{8'h00,8'h00,8'h76,8'hCC,8'hCC,8'h7C,8'h0C,8'hF8},
        '{8'hE0,8'h60,8'h6C,8'h76,8'h66,8'h66,8'hE6,8'h00},
        '{8'h30,8'h00,8'h70,8'h30,8'h30,8'h30,8'h78,8'h00},
        '{8'h0C,8'h00,8'h0C,8'h0C,8'h0C,8'hCC,8'hCC,8'h78},
        '{8'hE0,8'h60,8'h66,8'h6C,8'h78,8'h6C,8'hE6,8'h00},
        '{8'h70,8'h30,8'h30,8'h30,8'h30,8'h30,8'h78,8'h00},
        '{8'h00,8'h00,8'hCC,8'hFE,8'hFE,8'hD6,8'hC6,8'h00},
        '{8'h00,8'h00,8'hF8,8'hCC,8'hCC,8'hCC,8'hCC,8'h00},
        '{8'h00,8'h00,8'h78,8'hCC,8'hCC,8'hCC,8'h78,8'h00},
        '{8'h00,8'h00,8'hDC,8'h66,8'h66,8'h7C,8'h60,8'hF0},
        '{8'h00,8'h00,8'h76,8'hCC,8'hCC,8'h7C,8'h0C,8'h1E},
        '{8'h00,8'h00,8'h9C,8'h76,8'h66,8'h60,8'hF0,8'h00},
        '{8'h00,8'h00,8'h7C,8'hC0,8'h78,8'h0C,8'hF8,8'h00},
        '{8'h10,8'h30,8'h7C,8'h30,8'h30,8'h34,8'h18,8'h00},
        '{8'h00,8'h00,8'hCC,8'hCC,8'hCC,8'hCC,8'h76,8'h00},
        '{8'h00,8'h00,8'hCC,8'hCC,8'hCC,8'h78,8'h30,8'h00},
        '{8'h00,8'h00,8'hC6,8'hC6,8'hD6,8'hFE,8'h6C,8'h00},
        '{8'h00,8'h00,8'hC6,8'h6C,8'h38,8'h6C,8'hC6,8'h00},
        '{8'h00,8'h00,8'hCC,8'hCC,8'hCC,8'h7C,8'h0C,8'hF8},
        '{8'h00,8'h00,8'hFC,8'h98,8'h30,8'h64,8'hFC,8'h00},
        '{8'h78,8'hCC,8'hDC,8'hFC,8'hEC,8'hCC,8'h7C,8'h00},
        '{8'h30,8'h70,8'h30,8'h30,8'h30,8'h30,8'hFC,8'h00},
        '{8'h78,8'hCC,8'h0C,8'h38,8'h60,8'hCC,8'hFC,8'h00},
        '{8'h78,8'hCC,8'h0C,8'h38,8'h0C,8'hCC,8'h78,8'h00},
        '{8'h1C,8'h3C,8'h6C,8'hCC,8'hFE,8'h0C,8'h1E,8'h00},
        '{8'hFC,8'hC0,8'hF8,8'h0C,8'h0C,8'hCC,8'h78,8'h00},
        '{8'h38,8'h60,8'hC0,8'hF8,8'hCC,8'hCC,8'h78,8'h00},
        '{8'hFC,8'hCC,8'h0C,8'h18,8'h30,8'h30,8'h30,8'h00},
        '{8'h78,8'hCC,8'hCC,8'h78,8'hCC,8'hCC,8'h78,8'h00},
        '{8'h78,8'hCC,8'hCC,8'h7C,8'h0C,8'h18,8'h70,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h18,8'h30,8'h60,8'h60,8'h60,8'h30,8'h18,8'h00},
        '{8'h60,8'h30,8'h18,8'h18,8'h18,8'h30,8'h60,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h30,8'h30,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h30,8'h30,8'h60},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h7E,8'h7E},
        '{8'h00,8'h00,8'h00,8'h7E,8'h7E,8'h00,8'h00,8'h00},
        '{8'h78,8'hCC,8'h0C,8'h18,8'h30,8'h00,8'h30,8'h00},
        '{8'h18,8'h18,8'h18,8'h18,8'h18,8'h00,8'h18,8'h00},
        '{8'h18,8'h18,8'h00,8'h00,8'h18,8'h18,8'h00,8'h00},
        '{8'hC6,8'h38,8'h6C,8'hC6,8'hFE,8'hC6,8'hC6,8'h00},
        '{8'hCC,8'h00,8'h78,8'h0C,8'h7C,8'hCC,8'h7E,8'h00},
        '{8'hC3,8'h18,8'h3C,8'h66,8'h66,8'h3C,8'h18,8'h00},
        '{8'h00,8'hCC,8'h00,8'h78,8'hCC,8'hCC,8'h78,8'h00},
        '{8'hCC,8'h00,8'hCC,8'hCC,8'hCC,8'hCC,8'h78,8'h00},
        '{8'h00,8'hCC,8'h00,8'hCC,8'hCC,8'hCC,8'h7E,8'h00},
        '{8'h66,8'hFF,8'hFF,8'hFF,8'h7E,8'h3C,8'h18,8'h00},
        '{8'h3C,8'h42,8'hA5,8'h81,8'hA5,8'h99,8'h42,8'h3C},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01}
    };

    // glyph row byte, unknown glyphs are blank
    function automatic logic [7:0] font_row(input logic [GLYPH_W-1:0] g,
                                            input logic [2:0] j);
        logic [7:0] v;
        v = 8'h00;
        if (g < GLYPH_W'(GLYPH_COUNT)) begin
            v = FONT_ROWS[g][j];
        end
        return v;
    endfunction

    // glyph width in columns, unknown glyphs are eight wide
    function automatic logic [FW_W-1:0] font_width(input logic [GLYPH_W-1:0] g);
        logic [FW_W-1:0] w;
        case (g)
            7'd62:   w = 4'd4;
            7'd81:   w = 4'd1;
            7'd82:   w = 4'd2;
            7'd83:   w = 4'd3;
            7'd84:   w = 4'd1;
            default: w = 4'd8;
        endcase
        return w;
    endfunction

endpackage

// ===== hdl/scrolling_text_marquee_core.sv =====
// append, clear and restart items give no result
// a tick reads its glyph in the accept cycle and shifts the display chain once the
// output buffer is free, then offers one row per cycle while m_axis_tready is high
// a tick can be accepted while the eight-row buffer drains, then blocks further input
// synchronous active-low reset clears rows, text length, positions; config to 8 / 0
module scrolling_text_marquee_core #(
    parameter int MAX_DISPLAYS = stm_pkg::DEF_MAX_DISPLAYS,
    parameter int TEXT_DEPTH   = stm_pkg::DEF_TEXT_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [stm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // glyph_index[6:0], zero pad
    input  logic [1:0]                         s_axis_tuser,   // operation[1:0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [stm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // row_address[3:0],
                                                               // row_bits[67:4], wrapped[68]
    output logic                               m_axis_tlast,   // last_row
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [stm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [stm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [stm_pkg::DCNT_W-1:0]     r_dcnt;
    logic                           r_rev;
    logic                           r_s2_vld;
    logic [stm_pkg::ROW_BITS_W-1:0] r_ob [stm_pkg::ROWS];
    logic [3:0]                     r_ob_cnt;
    logic                           r_ob_wrap;

    logic [stm_pkg::DCNT_W-1:0]     act_cnt;
    logic                           in_acc;
    logic                           tick_acc;
    logic                           buf_free;
    logic                           fire;
    logic                           pop;
    logic [stm_pkg::ROWS-1:0]       fed;
    logic                           wrapped;
    logic [7:0]                     lsb [MAX_DISPLAYS];
    logic [7:0]                     msb [MAX_DISPLAYS];
    logic [7:0]                     lo_in [MAX_DISPLAYS];
    logic [7:0]                     hi_in [MAX_DISPLAYS];
    stm_pkg::t_rows                 rows_nxt [MAX_DISPLAYS];
    logic [stm_pkg::ROW_BITS_W-1:0] ob_load [stm_pkg::ROWS];
    logic [3:0]                     row_addr;
    stm_pkg::t_op                   op;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= stm_pkg::DCNT_W'(8);
            r_rev  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (stm_pkg::t_reg_idx'(i_cfg_index))
                stm_pkg::REG_DISPLAY_COUNT:  r_dcnt <= i_cfg_data;
                stm_pkg::REG_REVERSE_SCROLL: r_rev  <= i_cfg_data[0];
                default:                     r_rev  <= r_rev;
            endcase
        end
    end

    // active display count, zero acts as one, values above MAX_DISPLAYS act as MAX_DISPLAYS
    always_comb begin
        if (r_dcnt == '0) begin
            act_cnt = stm_pkg::DCNT_W'(1);
        end else if (r_dcnt > stm_pkg::DCNT_W'(MAX_DISPLAYS)) begin
            act_cnt = stm_pkg::DCNT_W'(MAX_DISPLAYS);
        end else begin
            act_cnt = r_dcnt;
        end
    end

    // input handshake, a tick waits in the shift stage for the output buffer
    assign op            = stm_pkg::t_op'(s_axis_tuser);
    assign s_axis_tready = !r_s2_vld;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign tick_acc      = in_acc && (op == stm_pkg::OP_TICK);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign buf_free      = (r_ob_cnt == 4'd0) || ((r_ob_cnt == 4'd1) && m_axis_tready);
    assign fire          = r_s2_vld && buf_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (tick_acc) begin
            r_s2_vld <= 1'b1;
        end else if (fire) begin
            r_s2_vld <= 1'b0;
        end
    end

    // text store, positions and glyph column
    stm_feed #(
        .TEXT_DEPTH(TEXT_DEPTH)
    ) u_feed (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item_acc (in_acc),
        .i_op       (op),
        .i_glyph    (s_axis_tdata[stm_pkg::GLYPH_W-1:0]),
        .i_commit   (fire),
        .i_reverse  (r_rev),
        .o_fed      (fed),
        .o_wrapped  (wrapped)
    );

    // chain of display cells
    for (genvar i = 0; i < MAX_DISPLAYS; i++) begin : g_cell
        stm_pkg::t_cell_ctl ctl;

        assign ctl.shift   = fire;
        assign ctl.reverse = r_rev;
        assign ctl.active  = (stm_pkg::DCNT_W'(i) < act_cnt);

        if (i == 0) begin : g_lo_first
            assign lo_in[i] = fed;
        end else begin : g_lo_chain
            assign lo_in[i] = lsb[i-1];
        end

        if (i == MAX_DISPLAYS - 1) begin : g_hi_last
            assign hi_in[i] = fed;
        end else begin : g_hi_chain
            assign hi_in[i] = (stm_pkg::DCNT_W'(i + 1) == act_cnt) ? fed : msb[i+1];
        end

        stm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_from_lo  (lo_in[i]),
            .i_from_hi  (hi_in[i]),
            .o_lsb      (lsb[i]),
            .o_msb      (msb[i]),
            .o_rows_nxt (rows_nxt[i])
        );
    end

    // pack shifted rows of the active displays
    always_comb begin
        for (int j = 0; j < stm_pkg::ROWS; j++) begin
            ob_load[j] = '0;
            for (int i = 0; i < MAX_DISPLAYS; i++) begin
                if (stm_pkg::DCNT_W'(i) < act_cnt) begin
                    ob_load[j][i*8 +: 8] = rows_nxt[i][j];
                end
            end
        end
    end

    // output buffer, one row item per cycle while m_axis_tready is high
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ob      <= ob_load;
            r_ob_wrap <= wrapped;
        end else if (pop) begin
            for (int k = 0; k < stm_pkg::ROWS - 1; k++) begin
                r_ob[k] <= r_ob[k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= 4'd0;
        end else if (fire) begin
            r_ob_cnt <= 4'(stm_pkg::ROWS);
        end else if (pop) begin
            r_ob_cnt <= r_ob_cnt - 4'd1;
        end
    end

    assign row_addr      = 4'(stm_pkg::ROWS + 1) - r_ob_cnt;
    assign m_axis_tvalid = (r_ob_cnt != 4'd0);
    assign m_axis_tlast  = (r_ob_cnt == 4'd1);
    assign m_axis_tdata  = {3'b000, r_ob_wrap, r_ob[0], row_addr};

endmodule

// ===== hdl/stm_cell.sv =====
module stm_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  stm_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]        i_from_lo,
    input  logic [7:0]        i_from_hi,
    output logic [7:0]        o_lsb,
    output logic [7:0]        o_msb,
    output stm_pkg::t_rows    o_rows_nxt
);

    stm_pkg::t_rows r_rows;
    stm_pkg::t_rows n_rows;

    // bits handed to the neighbors, one per row
    always_comb begin
        for (int j = 0; j < stm_pkg::ROWS; j++) begin
            o_lsb[j] = r_rows[j][0];
            o_msb[j] = r_rows[j][7];
        end
    end

    // one column shift in either direction
    always_comb begin
        n_rows = r_rows;
        if (i_ctl.shift && i_ctl.active) begin
            for (int j = 0; j < stm_pkg::ROWS; j++) begin
                if (i_ctl.reverse) begin
                    n_rows[j] = {r_rows[j][6:0], i_from_hi[j]};
                end else begin
                    n_rows[j] = {i_from_lo[j], r_rows[j][7:1]};
                end
            end
        end
    end

    assign o_rows_nxt = n_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
        end else begin
            r_rows <= n_rows;
        end
    end

endmodule

// ===== hdl/stm_feed.sv =====
module stm_feed #(
    parameter int TEXT_DEPTH = stm_pkg::DEF_TEXT_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_acc,
    input  stm_pkg::t_op                i_op,
    input  logic [stm_pkg::GLYPH_W-1:0] i_glyph,
    input  logic                        i_commit,
    input  logic                        i_reverse,
    output logic [stm_pkg::ROWS-1:0]    o_fed,
    output logic                        o_wrapped
);

    localparam int LW = $clog2(TEXT_DEPTH + 1);
    localparam int AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;

    logic [stm_pkg::GLYPH_W-1:0] r_mem [TEXT_DEPTH];
    logic [stm_pkg::GLYPH_W-1:0] r_rd;
    logic                        r_rd_ok;
    logic [LW-1:0]               r_length;
    logic [LW-1:0]               r_letter;
    logic [stm_pkg::COL_W-1:0]   r_col;

    logic [LW-1:0]               n_letter;
    logic [stm_pkg::COL_W-1:0]   n_col;
    logic [LW:0]                 letter_inc;
    logic [LW:0]                 letter_msk;
    logic [stm_pkg::FW_W-1:0]    col_inc;
    logic [stm_pkg::GLYPH_W-1:0] glyph;
    logic [stm_pkg::FW_W-1:0]    width;
    logic [stm_pkg::FW_W-1:0]    bit_idx;
    logic [7:0]                  row_byte;
    logic                        wrap;
    logic                        append_ok;
    logic                        tick_acc;

    assign append_ok = i_item_acc && (i_op == stm_pkg::OP_APPEND) &&
                       (r_length < LW'(TEXT_DEPTH));
    assign tick_acc  = i_item_acc && (i_op == stm_pkg::OP_TICK);

    // text store, entries at or past the length read as glyph zero
    always_ff @(posedge i_clk) begin
        if (append_ok) begin
            r_mem[r_length[AW-1:0]] <= i_glyph;
        end
        if (tick_acc) begin
            r_rd <= r_mem[r_letter[AW-1:0]];
        end
    end

    // current glyph and its fed column
    always_comb begin
        glyph    = r_rd_ok ? r_rd : '0;
        width    = stm_pkg::font_width(glyph);
        bit_idx  = width - 4'd1 - {1'b0, r_col};
        row_byte = '0;
        for (int j = 0; j < stm_pkg::ROWS; j++) begin
            row_byte = i_reverse ? stm_pkg::font_row(glyph, 3'(j))
                                 : stm_pkg::font_row(glyph, 3'(7 - j));
            o_fed[j] = ({1'b0, r_col} < width) ? row_byte[bit_idx[2:0]] : 1'b0;
        end
    end

    // column and letter advance, rewind at the end of the text
    always_comb begin
        col_inc    = {1'b0, r_col} + 4'd1;
        letter_inc = {1'b0, r_letter} + 1'b1;
        letter_msk = letter_inc & (LW+1)'(stm_pkg::POS_MASK);
        n_letter   = r_letter;
        n_col      = col_inc[stm_pkg::COL_W-1:0];
        if (col_inc >= width) begin
            n_letter = letter_msk[LW-1:0];
            n_col    = '0;
        end
        wrap = (n_letter >= r_length);
        if (wrap) begin
            n_letter = '0;
            n_col    = '0;
        end
    end

    assign o_wrapped = wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
            r_letter <= '0;
            r_col    <= '0;
            r_rd_ok  <= 1'b0;
        end else begin
            if (i_commit) begin
                r_letter <= n_letter;
                r_col    <= n_col;
            end else if (i_item_acc) begin
                case (i_op)
                    stm_pkg::OP_TICK: begin
                        r_rd_ok <= (r_letter < r_length);
                    end
                    stm_pkg::OP_APPEND: begin
                        if (append_ok) begin
                            r_length <= r_length + 1'b1;
                        end
                    end
                    stm_pkg::OP_CLEAR: begin
                        r_length <= '0;
                    end
                    stm_pkg::OP_RESTART: begin
                        r_letter <= '0;
                        r_col    <= '0;
                    end
                    default: begin
                        r_length <= r_length;
                    end
                endcase
            end
        end
    end

endmodule
